// ===== hw/rtl/mcfe_pkg.sv =====
package mcfe_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned CSR_INDEX_W = 8;

   // Pipeline: stencil, product, round, square, sum, difference, output
   localparam int unsigned NUM_STAGES  = 7;
   localparam int unsigned STG_STENCIL = 0;
   localparam int unsigned STG_PRODUCT = 1;
   localparam int unsigned STG_ROUND   = 2;
   localparam int unsigned STG_SQUARE  = 3;
   localparam int unsigned STG_SUM     = 4;
   localparam int unsigned STG_DIFF    = 5;
   localparam int unsigned STG_OUT     = 6;

   // Stencil of four 32 bit samples with weights 1, 8, 8, 1 needs 37 bits
   localparam int unsigned STENCIL_W = 37;
   localparam int unsigned MAG_W     = 36;
   localparam int unsigned LO_W      = 64;
   localparam int unsigned HI_W      = 36;
   localparam int unsigned PROD_W    = 69;
   localparam int unsigned SQ_W      = 64;

   localparam logic signed [DATA_W-1:0] SMAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SMIN = 32'sh8000_0000;

   localparam logic [CSR_INDEX_W-1:0] CSR_INV_TWELVE_DY     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_TWELVE_DX     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSPORT_ENABLE  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENERGY_FIX_ENABLE = 8'd3;

   typedef logic [NUM_STAGES-1:0] stage_adv_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pot_y_minus2;
      logic signed [DATA_W-1:0] pot_y_minus1;
      logic signed [DATA_W-1:0] pot_y_plus1;
      logic signed [DATA_W-1:0] pot_y_plus2;
      logic signed [DATA_W-1:0] pot_x_minus2;
      logic signed [DATA_W-1:0] pot_x_minus1;
      logic signed [DATA_W-1:0] pot_x_plus1;
      logic signed [DATA_W-1:0] pot_x_plus2;
      logic signed [DATA_W-1:0] old_energy;
      logic signed [DATA_W-1:0] old_field_x;
      logic signed [DATA_W-1:0] old_field_y;
      logic signed [DATA_W-1:0] old_field_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] new_energy;
      logic signed [DATA_W-1:0] new_field_x;
      logic signed [DATA_W-1:0] new_field_y;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] energy;
      logic signed [DATA_W-1:0] field_x;
      logic signed [DATA_W-1:0] field_y;
   } cell_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] curl_x;
      logic signed [DATA_W-1:0] curl_y;
   } curl_pair_type;

endpackage

// ===== hw/rtl/mcfe_curl_lane.sv =====
module mcfe_curl_lane #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  mcfe_pkg::stage_adv_type                adv,
   input  logic signed [mcfe_pkg::DATA_W-1:0]     pot_minus2,
   input  logic signed [mcfe_pkg::DATA_W-1:0]     pot_minus1,
   input  logic signed [mcfe_pkg::DATA_W-1:0]     pot_plus1,
   input  logic signed [mcfe_pkg::DATA_W-1:0]     pot_plus2,
   input  logic        [mcfe_pkg::DATA_W-1:0]     inv_scale,
   input  logic                                   invert_sign,
   output logic signed [mcfe_pkg::DATA_W-1:0]     field_ff,
   output logic        [mcfe_pkg::DATA_W-1:0]     field_mag_ff
);
   import mcfe_pkg::*;

   logic signed [STENCIL_W-1:0] sten;
   logic        [MAG_W-1:0]     mag_in, mag_ff;
   logic                        neg_in, neg_ff, neg1_ff;
   logic        [LO_W-1:0]      lo_in, lo_ff;
   logic        [HI_W-1:0]      hi_in, hi_ff;
   logic        [PROD_W-1:0]    sum;
   logic                        ovf;
   logic        [DATA_W-2:0]    q;
   logic signed [DATA_W-1:0]    field_in;
   logic        [DATA_W-1:0]    field_mag_in;

   // Stencil and sign/magnitude split
   assign sten = STENCIL_W'(pot_minus2) - (STENCIL_W'(pot_minus1) <<< 3)
               + (STENCIL_W'(pot_plus1) <<< 3) - STENCIL_W'(pot_plus2);
   assign neg_in = sten[STENCIL_W-1] ^ invert_sign;
   assign mag_in = sten[STENCIL_W-1] ? MAG_W'(-sten) : MAG_W'(sten);

   // Split the magnitude into a 32 bit low part and a 4 bit high part
   assign lo_in = LO_W'(mag_ff[DATA_W-1:0]) * LO_W'(inv_scale);
   assign hi_in = HI_W'(mag_ff[MAG_W-1:DATA_W]) * HI_W'(inv_scale);

   // Round half away from zero on the magnitude, then saturate
   assign sum = PROD_W'(lo_ff) + (PROD_W'(hi_ff) << DATA_W)
              + (PROD_W'(1) << (FRAC_BITS - 1));
   assign ovf = |sum[PROD_W-1:FRAC_BITS+DATA_W-1];
   assign q   = sum[FRAC_BITS+DATA_W-2:FRAC_BITS];

   always_comb begin
      if (neg1_ff) begin
         field_in     = ovf ? SMIN : -signed'({1'b0, q});
         field_mag_in = ovf ? DATA_W'(SMIN) : {1'b0, q};
      end else begin
         field_in     = ovf ? SMAX : signed'({1'b0, q});
         field_mag_in = ovf ? DATA_W'(SMAX) : {1'b0, q};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[STG_STENCIL]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      if (adv[STG_PRODUCT]) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         neg1_ff <= neg_ff;
      end
      if (adv[STG_ROUND]) begin
         field_ff     <= field_in;
         field_mag_ff <= field_mag_in;
      end
   end

endmodule

// ===== hw/rtl/mcfe_energy.sv =====
module mcfe_energy (
   input  logic                                clock,
   input  mcfe_pkg::stage_adv_type             adv,
   input  logic signed [mcfe_pkg::DATA_W-1:0]  old_field_x,
   input  logic signed [mcfe_pkg::DATA_W-1:0]  old_field_y,
   input  logic signed [mcfe_pkg::DATA_W-1:0]  old_field_z,
   input  logic        [mcfe_pkg::DATA_W-1:0]  curl_x_mag,
   input  logic        [mcfe_pkg::DATA_W-1:0]  curl_y_mag,
   output logic                                up_ff,
   output logic        [mcfe_pkg::SQ_W-1:0]    diff_ff
);
   import mcfe_pkg::*;

   logic [DATA_W-1:0] abs_x_ff, abs_y_ff, abs_z_ff;
   logic [SQ_W-1:0]   sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SQ_W-1:0]   old_xy_ff, sq_z2_ff;
   logic [SQ_W-1:0]   sq_cx_ff, sq_cy_ff, old_ff, sq_z3_ff;
   logic [SQ_W-1:0]   new_sum_ff, old4_ff;

   // Sums stay below 2^64: each square is at most 2^62
   always_ff @(posedge clock) begin
      if (adv[STG_STENCIL]) begin
         abs_x_ff <= old_field_x[DATA_W-1] ? DATA_W'(-old_field_x) : DATA_W'(old_field_x);
         abs_y_ff <= old_field_y[DATA_W-1] ? DATA_W'(-old_field_y) : DATA_W'(old_field_y);
         abs_z_ff <= old_field_z[DATA_W-1] ? DATA_W'(-old_field_z) : DATA_W'(old_field_z);
      end
      if (adv[STG_PRODUCT]) begin
         sq_x_ff <= SQ_W'(abs_x_ff) * SQ_W'(abs_x_ff);
         sq_y_ff <= SQ_W'(abs_y_ff) * SQ_W'(abs_y_ff);
         sq_z_ff <= SQ_W'(abs_z_ff) * SQ_W'(abs_z_ff);
      end
      if (adv[STG_ROUND]) begin
         old_xy_ff <= sq_x_ff + sq_y_ff;
         sq_z2_ff  <= sq_z_ff;
      end
      if (adv[STG_SQUARE]) begin
         sq_cx_ff <= SQ_W'(curl_x_mag) * SQ_W'(curl_x_mag);
         sq_cy_ff <= SQ_W'(curl_y_mag) * SQ_W'(curl_y_mag);
         old_ff   <= old_xy_ff + sq_z2_ff;
         sq_z3_ff <= sq_z2_ff;
      end
      if (adv[STG_SUM]) begin
         new_sum_ff <= sq_cx_ff + sq_cy_ff + sq_z3_ff;
         old4_ff    <= old_ff;
      end
      if (adv[STG_DIFF]) begin
         up_ff   <= new_sum_ff >= old4_ff;
         diff_ff <= (new_sum_ff >= old4_ff) ? new_sum_ff - old4_ff : old4_ff - new_sum_ff;
      end
   end

endmodule

// ===== hw/rtl/mhd_curl_field_energy_fix_top.sv =====
// Channel   Ports                          Direction  Moves
// request   req_valid/req_ready/req_data   in         potentials and old cell values
// response  rsp_valid/rsp_ready/rsp_data   out        new energy and field x/y
// csr       csr_wr_en/csr_index/csr_wr_data in        scale factors and enables
//
// One request per cycle while no stalled response backs up the pipeline; a response
// becomes valid once its request has passed through the seven register stages.
// Reset clears the stage valid bits and loads the csr defaults (scales 1.0,
// both enables off).
// A stalled response holds its stage; the stages behind it fill their
// bubbles first and only then hold, so nothing is lost or repeated.
module mhd_curl_field_energy_fix_top #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  mcfe_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output mcfe_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [mcfe_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mcfe_pkg::DATA_W-1:0]           csr_wr_data
);
   import mcfe_pkg::*;

   localparam int unsigned HALF_W = 64 - FRAC_BITS;
   localparam int unsigned ESUM_W = HALF_W + 2;

   // Configuration registers
   logic [DATA_W-1:0] inv_dy_ff, inv_dx_ff;
   logic              transport_ff, energy_fix_ff;

   // Pipeline control
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   stage_adv_type         adv;

   // Carried cell values and curl results
   cell_type      cell_ff [STG_STENCIL:STG_DIFF];
   curl_pair_type curl_ff [STG_SQUARE:STG_DIFF];

   logic signed [DATA_W-1:0] curl_x, curl_y;
   logic        [DATA_W-1:0] curl_x_mag, curl_y_mag;
   logic                     up;
   logic        [SQ_W-1:0]   diff;

   logic        [HALF_W-1:0] half;
   logic signed [ESUM_W-1:0] e_wide, h_wide, e_sum;
   logic signed [DATA_W-1:0] e_sat;
   rsp_type                  rsp_in, rsp_ff;

   // Take csr writes; ignore indexes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_dy_ff     <= DATA_W'(1) << FRAC_BITS;
         inv_dx_ff     <= DATA_W'(1) << FRAC_BITS;
         transport_ff  <= 1'b0;
         energy_fix_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_INV_TWELVE_DY:     inv_dy_ff     <= csr_wr_data;
            CSR_INV_TWELVE_DX:     inv_dx_ff     <= csr_wr_data;
            CSR_TRANSPORT_ENABLE:  transport_ff  <= csr_wr_data[0];
            CSR_ENERGY_FIX_ENABLE: energy_fix_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // A stage advances when it is empty or the stage after it advances
   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      valid_in[0] = adv[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = adv[STG_STENCIL];

   // B1 along y, B2 negated along x
   mcfe_curl_lane #(.FRAC_BITS(FRAC_BITS)) u_curl_x (
      .clock        (clock),
      .adv          (adv),
      .pot_minus2   (req_data.pot_y_minus2),
      .pot_minus1   (req_data.pot_y_minus1),
      .pot_plus1    (req_data.pot_y_plus1),
      .pot_plus2    (req_data.pot_y_plus2),
      .inv_scale    (inv_dy_ff),
      .invert_sign  (1'b0),
      .field_ff     (curl_x),
      .field_mag_ff (curl_x_mag)
   );

   mcfe_curl_lane #(.FRAC_BITS(FRAC_BITS)) u_curl_y (
      .clock        (clock),
      .adv          (adv),
      .pot_minus2   (req_data.pot_x_minus2),
      .pot_minus1   (req_data.pot_x_minus1),
      .pot_plus1    (req_data.pot_x_plus1),
      .pot_plus2    (req_data.pot_x_plus2),
      .inv_scale    (inv_dx_ff),
      .invert_sign  (1'b1),
      .field_ff     (curl_y),
      .field_mag_ff (curl_y_mag)
   );

   mcfe_energy u_energy (
      .clock       (clock),
      .adv         (adv),
      .old_field_x (req_data.old_field_x),
      .old_field_y (req_data.old_field_y),
      .old_field_z (req_data.old_field_z),
      .curl_x_mag  (curl_x_mag),
      .curl_y_mag  (curl_y_mag),
      .up_ff       (up),
      .diff_ff     (diff)
   );

   // Carry the old cell values and the curl results alongside the math
   always_ff @(posedge clock) begin
      if (adv[STG_STENCIL]) begin
         cell_ff[STG_STENCIL] <= '{energy:  req_data.old_energy,
                                   field_x: req_data.old_field_x,
                                   field_y: req_data.old_field_y};
      end
      if (adv[STG_SQUARE]) begin
         curl_ff[STG_SQUARE] <= '{curl_x: curl_x, curl_y: curl_y};
      end
   end

   for (genvar s = STG_PRODUCT; s <= STG_DIFF; s++) begin : g_cell
      always_ff @(posedge clock) begin
         if (adv[s]) begin
            cell_ff[s] <= cell_ff[s-1];
         end
      end
   end

   for (genvar s = STG_SUM; s <= STG_DIFF; s++) begin : g_curl
      always_ff @(posedge clock) begin
         if (adv[s]) begin
            curl_ff[s] <= curl_ff[s-1];
         end
      end
   end

   // Half the field energy change, rounded half away from zero on magnitude
   assign half   = HALF_W'(diff[SQ_W-1:FRAC_BITS+1]) + HALF_W'(diff[FRAC_BITS]);
   assign e_wide = ESUM_W'(cell_ff[STG_DIFF].energy);
   assign h_wide = signed'(ESUM_W'(half));
   assign e_sum  = up ? e_wide + h_wide : e_wide - h_wide;

   always_comb begin
      if (e_sum > ESUM_W'(SMAX)) begin
         e_sat = SMAX;
      end else if (e_sum < ESUM_W'(SMIN)) begin
         e_sat = SMIN;
      end else begin
         e_sat = e_sum[DATA_W-1:0];
      end
   end

   always_comb begin
      rsp_in.new_energy  = energy_fix_ff ? e_sat : cell_ff[STG_DIFF].energy;
      rsp_in.new_field_x = transport_ff ? curl_ff[STG_DIFF].curl_x : cell_ff[STG_DIFF].field_x;
      rsp_in.new_field_y = transport_ff ? curl_ff[STG_DIFF].curl_y : cell_ff[STG_DIFF].field_y;
   end

   // Output register: hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (adv[STG_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[STG_OUT];
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // A held stage keeps its request
   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((valid_ff & $past(valid_ff & ~adv)) == $past(valid_ff & ~adv)))
      else $error("stalled stage dropped its request");

   // Back pressure only with every stage full and the consumer stalled
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ((&valid_ff) && !rsp_ready))
      else $error("request blocked while a bubble remains");

   // An accepted request lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> valid_ff[STG_STENCIL])
      else $error("accepted request lost at entry");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");
`endif

endmodule

// ===== verif/tb_mhd_curl_field_energy_fix_top.sv =====
module tb_mhd_curl_field_energy_fix_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mcfe_pkg::*;

   localparam int unsigned FRAC            = 16;
   localparam int unsigned RAND_PHASES     = 8;
   localparam int unsigned CELLS_PER_PHASE = 225;
   localparam int unsigned LONG_HOLD       = 400;

   // Indexes past the register list; writes there must leave every register alone
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LOW = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_TOP = 8'hFF;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_type                req_data    = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [DATA_W-1:0]      csr_wr_data = '0;

   // Shadow copy of the block's registers, at their reset values
   logic [DATA_W-1:0] scale_y       = 32'h0001_0000;
   logic [DATA_W-1:0] scale_x       = 32'h0001_0000;
   bit                transport_on  = 1'b0;
   bit                energy_fix_on = 1'b0;

   req_type     pending_cells[$];
   rsp_type     expected_cells[$];
   bit          req_taken       = 1'b0;
   int unsigned send_idle_pct   = 0;
   int unsigned rsp_stall_pct   = 0;
   bit          long_hold_arm   = 1'b0;
   bit          long_hold_ack   = 1'b0;
   int unsigned long_hold_left  = 0;
   int unsigned cells_queued    = 0;
   int unsigned cells_checked   = 0;
   int unsigned mismatches      = 0;
   int unsigned settings_used   = 0;

   mhd_curl_field_energy_fix_top #(
      .FRAC_BITS(FRAC)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #5ns clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Fourth-order stencil times the unsigned reciprocal, rounded half away
   // from zero and saturated; flip negates the result (the x direction).
   function automatic logic signed [31:0] curl_component(
      input logic signed [31:0] m2, m1, p1, p2,
      input logic [31:0] scale,
      input bit flip);
      longint      stencil;
      logic [63:0] mag;
      logic [79:0] scaled;
      bit          neg;
      stencil = longint'(m2) - 8 * longint'(m1) + 8 * longint'(p1) - longint'(p2);
      neg = stencil < 0;
      mag = neg ? -stencil : stencil;
      scaled = (80'(mag) * 80'(scale) + (80'(1) << (FRAC - 1))) >> FRAC;
      if (flip)
         neg = !neg;
      // a magnitude of exactly 2^31 still fits when negative
      if (scaled >= 80'h8000_0000)
         return neg ? SMIN : SMAX;
      return neg ? -$signed(scaled[31:0]) : $signed(scaled[31:0]);
   endfunction

   function automatic logic [65:0] square_of(input logic signed [31:0] v);
      logic [63:0] m;
      m = (v < 0) ? 64'(-longint'(v)) : 64'(longint'(v));
      return 66'(m) * 66'(m);
   endfunction

   function automatic rsp_type predict_cell(input req_type c);
      rsp_type            r;
      logic signed [31:0] curl_x;
      logic signed [31:0] curl_y;
      logic [65:0]        new_sq;
      logic [65:0]        old_sq;
      logic [65:0]        diff;
      logic [65:0]        half;
      longint             e;
      curl_x = curl_component(c.pot_y_minus2, c.pot_y_minus1, c.pot_y_plus1,
                              c.pot_y_plus2, scale_y, 1'b0);
      curl_y = curl_component(c.pot_x_minus2, c.pot_x_minus1, c.pot_x_plus1,
                              c.pot_x_plus2, scale_x, 1'b1);
      r.new_field_x = transport_on ? curl_x : c.old_field_x;
      r.new_field_y = transport_on ? curl_y : c.old_field_y;
      e = longint'(c.old_energy);
      // The new field energy always uses the curl values, transport or not
      if (energy_fix_on) begin
         new_sq = square_of(curl_x) + square_of(curl_y) + square_of(c.old_field_z);
         old_sq = square_of(c.old_field_x) + square_of(c.old_field_y)
                + square_of(c.old_field_z);
         diff = (new_sq >= old_sq) ? new_sq - old_sq : old_sq - new_sq;
         half = (diff >> (FRAC + 1)) + diff[FRAC];
         e = (new_sq >= old_sq) ? e + longint'(half) : e - longint'(half);
         if (e > longint'(SMAX))
            e = SMAX;
         else if (e < longint'(SMIN))
            e = SMIN;
      end
      r.new_energy = e[31:0];
      return r;
   endfunction

   function automatic void check_field(input string name,
                                       input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic logic signed [31:0] rand_sample();
      case ($urandom_range(5))
         0, 1: return $urandom;
         2: return int'($urandom_range(1 << 19)) - (1 << 18);
         3: return int'($urandom_range(1 << 26)) - (1 << 25);
         4: begin
            case ($urandom_range(4))
               0: return SMAX;
               1: return SMIN;
               2: return 0;
               3: return 1;
               default: return -1;
            endcase
         end
         default: return int'($urandom_range(600)) - 300;
      endcase
   endfunction

   // Independent samples, or now and then a smooth potential so the curl
   // stays moderate and the energy correction does not just saturate
   function automatic req_type make_random_cell();
      req_type            c;
      logic signed [31:0] base;
      logic signed [31:0] slope;
      for (int k = 0; k < 12; k++)
         c[k*32 +: 32] = rand_sample();
      if ($urandom_range(2) == 0) begin
         base  = rand_sample();
         slope = int'($urandom_range(1 << 17)) - (1 << 16);
         c.pot_y_minus2 = base - 2 * slope;
         c.pot_y_minus1 = base - slope;
         c.pot_y_plus1  = base + slope;
         c.pot_y_plus2  = base + 2 * slope;
         slope = int'($urandom_range(1 << 17)) - (1 << 16);
         c.pot_x_minus2 = base - 2 * slope;
         c.pot_x_minus1 = base - slope;
         c.pot_x_plus1  = base + slope;
         c.pot_x_plus2  = base + 2 * slope;
      end
      return c;
   endfunction

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h0001_0000;
         3: return $urandom;
         4: return $urandom_range(1 << 18);
         default: return $urandom_range(1 << 14);
      endcase
   endfunction

   task automatic queue_cell(input req_type c);
      pending_cells.push_back(c);
      cells_queued++;
   endtask

   // Write one register while the block is idle; mirror it in the shadow copy
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_INV_TWELVE_DY:     scale_y = value;
         CSR_INV_TWELVE_DX:     scale_x = value;
         CSR_TRANSPORT_ENABLE:  transport_on = value[0];
         CSR_ENERGY_FIX_ENABLE: energy_fix_on = value[0];
         default: ;
      endcase
   endtask

   // Hold until every queued request has come back, then let the pipe settle
   task automatic wait_for_drain();
      while (cells_checked != cells_queued)
         @(negedge clock);
      repeat (NUM_STAGES + 2) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: drive at the falling edge, advance only after the
   // current request was taken, idle at random
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_cells.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response sink: random stalls, plus one long hold-off counted here
   // whenever the stimulus toggles the arm flag
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready      <= 1'b0;
         long_hold_left <= 0;
      end else if (long_hold_arm != long_hold_ack) begin
         long_hold_ack  <= long_hold_arm;
         long_hold_left <= LONG_HOLD;
         rsp_ready      <= 1'b0;
      end else if (long_hold_left != 0) begin
         long_hold_left <= long_hold_left - 1;
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: at the rising edge, check a taken response against the oldest
   // expectation first, then predict a taken request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      req_taken = !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cells.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_data);
            mismatches++;
         end else begin
            want = expected_cells.pop_front();
            check_field("new_energy", want.new_energy, rsp_data.new_energy);
            check_field("new_field_x", want.new_field_x, rsp_data.new_field_x);
            check_field("new_field_y", want.new_field_y, rsp_data.new_field_y);
            cells_checked++;
         end
      end
      if (req_taken)
         expected_cells.push_back(predict_cell(req_data));
   end

   // ---------------------------------------------------------------------
   // Stimulus sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 9;
      rsp_stall_pct = 9;
      settings_used = 1;

      // Reset settings: both enables off, so old values pass through
      queue_cell('0);
      queue_cell(req_type'({12{SMAX}}));
      queue_cell(req_type'({12{SMIN}}));
      queue_cell(make_random_cell());
      wait_for_drain();

      // Half scales, everything on; the stray writes must not alias onto
      // a real register
      write_reg(CSR_INV_TWELVE_DY, 32'h0000_8000);
      write_reg(CSR_INV_TWELVE_DX, 32'h0000_8000);
      write_reg(CSR_TRANSPORT_ENABLE, 32'd1);
      write_reg(CSR_ENERGY_FIX_ENABLE, 32'd1);
      write_reg(CSR_UNMAPPED_LOW, 32'd0);
      write_reg(CSR_UNMAPPED_TOP, 32'd0);
      settings_used++;
      // curl of exactly one half rounds away from zero, both signs
      queue_cell(req_type'{32'sd1, 0, 0, 0, 32'sd1, 0, 0, 0, 0, 0, 0, 0});
      queue_cell(req_type'{-32'sd1, 0, 0, 0, -32'sd1, 0, 0, 0, 0, 0, 0, 0});
      queue_cell(req_type'{32'sd3, 0, 0, 0, -32'sd3, 0, 0, 0, 32'sd7, 0, 0, 0});
      // stencil extremes saturate the curl and the energy
      queue_cell(req_type'{SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN,
                           0, 0, 0, 0});
      queue_cell(req_type'{SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX,
                           SMAX, 0, 0, 0});
      // old field at its extreme drives the energy to the floor
      queue_cell(req_type'{0, 0, 0, 0, 0, 0, 0, 0, SMIN, SMIN, SMIN, SMIN});
      // energy change of exactly half an LSB, both field signs
      queue_cell(req_type'{0, 0, 0, 0, 0, 0, 0, 0, 32'sd100, 32'sd256, 0, 32'sd12345});
      queue_cell(req_type'{0, 0, 0, 0, 0, 0, 0, 0, 32'sd100, -32'sd256, 0,
                           -32'sd12345});
      wait_for_drain();

      // Scale extremes; only bit 0 of an enable write counts
      write_reg(CSR_INV_TWELVE_DY, 32'h0000_0000);
      write_reg(CSR_INV_TWELVE_DX, 32'hFFFF_FFFF);
      write_reg(CSR_TRANSPORT_ENABLE, 32'd3);
      write_reg(CSR_ENERGY_FIX_ENABLE, 32'd2);
      settings_used++;
      queue_cell(req_type'{SMAX, SMIN, SMAX, SMIN, 32'sd1, 0, 0, 0,
                           0, 32'sd5, 32'sd6, 32'sd7});
      // a rounded magnitude of exactly 2^31: fits negative, clips positive
      queue_cell(req_type'{32'sd5, 32'sd6, 32'sd7, 32'sd8, 32'sh8000, 0, 0, 0,
                           0, 0, 0, 0});
      queue_cell(req_type'{32'sd5, 32'sd6, 32'sd7, 32'sd8, -32'sh8000, 0, 0, 0,
                           0, 0, 0, 0});
      queue_cell(make_random_cell());
      queue_cell(make_random_cell());
      wait_for_drain();

      // Random phases: every enable combination twice, new scales each time,
      // idle modes rotating through none, sender, receiver and both
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         write_reg(CSR_INV_TWELVE_DY, pick_scale());
         write_reg(CSR_INV_TWELVE_DX, pick_scale());
         write_reg(CSR_TRANSPORT_ENABLE, (32'($urandom) & ~32'd1) | ph[0]);
         write_reg(CSR_ENERGY_FIX_ENABLE, (32'($urandom) & ~32'd1) | ph[1]);
         settings_used++;
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 75;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 75;
            end
            default: begin
               send_idle_pct = 9;
               rsp_stall_pct = 9;
            end
         endcase
         if (ph == 4) begin
            // Fill the pipe: the sender keeps offering while the sink holds off
            repeat (CELLS_PER_PHASE) queue_cell(make_random_cell());
            long_hold_arm = !long_hold_arm;
         end else if (ph == 2) begin
            // Pause the sender mid-phase until every response is back
            repeat (CELLS_PER_PHASE / 2) queue_cell(make_random_cell());
            wait_for_drain();
            repeat (CELLS_PER_PHASE - CELLS_PER_PHASE / 2)
               queue_cell(make_random_cell());
         end else begin
            repeat (CELLS_PER_PHASE) queue_cell(make_random_cell());
         end
         wait_for_drain();
      end

      // Give stray responses time to show up
      repeat (2 * NUM_STAGES) @(negedge clock);
      $display("Checked %0d cells under %0d register settings: pass-through, rounding,",
               cells_checked, settings_used);
      $display("saturation, all enable pairs, four idle mixes and a %0d-cycle sink hold.",
               LONG_HOLD);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== mhd_curl_field_energy_fix_top.f =====
hw/rtl/mcfe_pkg.sv
hw/rtl/mcfe_curl_lane.sv
hw/rtl/mcfe_energy.sv
hw/rtl/mhd_curl_field_energy_fix_top.sv
verif/tb_mhd_curl_field_energy_fix_top.sv
